// ===== rtl/njqd_pkg.sv =====
// Shared types, codes and constants of the storage job queue dispatcher.
`timescale 1ns / 1ps
package njqd_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int MAX_BLOCKS  = 8;
    localparam int RING_SLOTS  = QUEUE_DEPTH + 1;
    localparam int PTR_W       = $clog2(RING_SLOTS);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int BLK_W       = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;

    localparam int IN_W        = 16;
    localparam int OUT_W       = 24;

    // Actions
    localparam logic [1:0] ACT_ADD   = 2'd0;
    localparam logic [1:0] ACT_TICK  = 2'd1;
    localparam logic [1:0] ACT_QUERY = 2'd2;

    // Job kinds
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_WRITE = 2'd2;

    // Driver result codes
    localparam logic [2:0] DRV_OK   = 3'd0;
    localparam logic [2:0] DRV_BUSY = 3'd1;
    localparam logic [2:0] DRV_ADDR = 3'd2;
    localparam logic [2:0] DRV_FAIL = 3'd3;

    // Data status codes
    localparam logic [2:0] DS_OK         = 3'd0;
    localparam logic [2:0] DS_CSUM_ERR   = 3'd1;
    localparam logic [2:0] DS_ID_ERR     = 3'd2;
    localparam logic [2:0] DS_WRITE_OK   = 3'd3;
    localparam logic [2:0] DS_READ_FAIL  = 3'd4;
    localparam logic [2:0] DS_WRITE_FAIL = 3'd5;
    localparam logic [2:0] DS_INVALID    = 3'd6;

    // Operation status codes
    localparam logic [2:0] OS_IDLE      = 3'd0;
    localparam logic [2:0] OS_READING   = 3'd1;
    localparam logic [2:0] OS_WRITING   = 3'd2;
    localparam logic [2:0] OS_READ_ERR  = 3'd3;
    localparam logic [2:0] OS_WRITE_ERR = 3'd4;

    // Last result codes
    localparam logic [1:0] LR_OK     = 2'd0;
    localparam logic [1:0] LR_FAILED = 2'd1;
    localparam logic [1:0] LR_BUSY   = 2'd2;

    // Register indexes
    localparam logic [0:0] REG_BLOCK_COUNT = 1'd0;
    localparam logic [0:0] REG_WAIT_LIMIT  = 1'd1;

    localparam logic [15:0] WAIT_LIMIT_RST  = 16'd1000;
    localparam logic [3:0]  BLOCK_COUNT_RST = 4'd8;

    // Classified item passed from front to back
    typedef struct packed {
        logic [1:0] action;
        logic [3:0] block;
        logic       write;
        logic       job_ok;
        logic       force_req;
        logic       driver_idle;
        logic [2:0] driver_result;
        logic       id_ok;
        logic       checksum_ok;
    } cmd_t;

    typedef struct packed {
        logic       add_accepted;
        logic       issue_valid;
        logic [2:0] issue_block;
        logic       issue_write;
        logic       finish_valid;
        logic       engine_idle;
        logic [2:0] query_data_status;
        logic [2:0] query_op_status;
        logic [1:0] query_last_result;
        logic [4:0] queue_count;
    } res_t;

endpackage

// ===== rtl/njqd_front.sv =====
// Front end: accepts input items, unpacks them and classifies add requests.
`timescale 1ns / 1ps
module njqd_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         in_user,
    input  logic [12:0]        in_data,
    input  logic [3:0]         block_count,
    output logic               cmd_valid,
    input  logic               cmd_ready,
    output njqd_pkg::cmd_t     cmd
);
    import njqd_pkg::*;

    logic       valid_reg;
    cmd_t       cmd_reg;
    cmd_t       cmd_next;
    logic [1:0] op;
    logic [3:0] blk;

    assign in_ready  = !valid_reg || cmd_ready;
    assign cmd_valid = valid_reg;
    assign cmd       = cmd_reg;

    // Unpack and classify
    always_comb
    begin
        blk = in_data[3:0];
        op  = in_data[5:4];
        cmd_next.action        = in_user;
        cmd_next.block         = blk;
        cmd_next.write         = (op == OP_WRITE);
        cmd_next.job_ok        = (op == OP_READ || op == OP_WRITE)
                                 && (blk < block_count) && (blk < 4'(MAX_BLOCKS));
        cmd_next.force_req     = in_data[6];
        cmd_next.driver_idle   = in_data[7];
        cmd_next.driver_result = in_data[10:8];
        cmd_next.id_ok         = in_data[11];
        cmd_next.checksum_ok   = in_data[12];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            cmd_reg <= cmd_next;
    end
endmodule

// ===== rtl/njqd_back.sv =====
// Back end: job ring, duplicate scan, dispatch engine and per-block status.
`timescale 1ns / 1ps
module njqd_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cmd_valid,
    output logic           cmd_ready,
    input  njqd_pkg::cmd_t cmd,
    input  logic [3:0]     block_count,
    input  logic [15:0]    wait_limit,
    output logic           res_valid,
    input  logic           res_ready,
    output njqd_pkg::res_t res
);
    import njqd_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]       state_reg, state_next;
    logic [PTR_W-1:0] head_reg, tail_reg, scan_reg;
    logic             waiting_reg;
    logic [BLK_W-1:0] cur_blk_reg;
    logic             cur_wr_reg;
    logic [15:0]      wcnt_reg;
    logic [2:0]       ds_reg [MAX_BLOCKS];
    logic [2:0]       os_reg [MAX_BLOCKS];
    logic [1:0]       lr_reg [MAX_BLOCKS];
    logic [BLK_W:0]   q_blk  [RING_SLOTS];
    logic             dup_reg;
    logic             res_valid_reg;
    res_t             res_reg, res_next;

    logic [PTR_W-1:0] head_inc, tail_inc, scan_inc;
    logic [CNT_W-1:0] count, count_after;
    logic [PTR_W-1:0] head_new, tail_new;
    logic             hit;
    logic             pop_blk_ok;
    logic [BLK_W-1:0] qb;
    logic             qw;
    logic [BLK_W-1:0] cb;

    function automatic logic [PTR_W-1:0] ring_inc(input logic [PTR_W-1:0] i);
        return (i == PTR_W'(RING_SLOTS - 1)) ? '0 : i + 1'b1;
    endfunction

    function automatic logic [CNT_W-1:0] ring_cnt(input logic [PTR_W-1:0] t,
                                                  input logic [PTR_W-1:0] h);
        return (t >= h) ? CNT_W'(t - h) : CNT_W'(t + PTR_W'(RING_SLOTS) - h);
    endfunction

    assign head_inc = ring_inc(head_reg);
    assign tail_inc = ring_inc(tail_reg);
    assign scan_inc = ring_inc(scan_reg);
    assign count    = ring_cnt(tail_reg, head_reg);
    assign hit      = (q_blk[scan_reg] == {cmd.write, cmd.block[BLK_W-1:0]});
    assign qb       = q_blk[head_reg][BLK_W-1:0];
    assign qw       = q_blk[head_reg][BLK_W];
    assign pop_blk_ok = (4'(qb) < block_count);
    assign cb       = cmd.block[BLK_W-1:0];

    assign cmd_ready = (state_reg == ST_DONE) && (!res_valid_reg || res_ready);
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    // Head/tail after this item's effect, for the status fields
    always_comb
    begin
        head_new = head_reg;
        tail_new = tail_reg;
        if (cmd.action == ACT_ADD && cmd.job_ok && !dup_reg)
        begin
            if (count >= CNT_W'(QUEUE_DEPTH))
            begin
                if (cmd.force_req)
                begin
                    head_new = head_inc;
                    tail_new = tail_inc;
                end
            end
            else
                tail_new = tail_inc;
        end
        else if (cmd.action == ACT_TICK && !waiting_reg && cmd.driver_idle
                 && count != '0)
            head_new = head_inc;
        count_after = ring_cnt(tail_new, head_new);
    end

    // Assemble the result item
    always_comb
    begin
        logic wait_next;
        res_next = '0;
        wait_next = waiting_reg;
        case (cmd.action)
            ACT_ADD:
                res_next.add_accepted = cmd.job_ok && !dup_reg
                    && (count < CNT_W'(QUEUE_DEPTH) || cmd.force_req);
            ACT_TICK:
            begin
                if (!waiting_reg)
                begin
                    if (cmd.driver_idle && count != '0 && pop_blk_ok)
                    begin
                        res_next.issue_valid = 1'b1;
                        res_next.issue_block = 3'(qb);
                        res_next.issue_write = qw;
                        wait_next = 1'b1;
                    end
                end
                else if (cmd.driver_idle &&
                         !(cmd.driver_result == DRV_BUSY && wcnt_reg != '0))
                begin
                    res_next.finish_valid = 1'b1;
                    wait_next = 1'b0;
                end
            end
            ACT_QUERY:
            begin
                if (cmd.block < block_count && cmd.block < 4'(MAX_BLOCKS))
                begin
                    res_next.query_data_status = ds_reg[cb];
                    res_next.query_op_status   = os_reg[cb];
                    res_next.query_last_result = lr_reg[cb];
                end
                else
                    res_next.query_data_status = DS_INVALID;
            end
            default: ;
        endcase
        res_next.engine_idle = (count_after == '0) && cmd.driver_idle && !wait_next;
        res_next.queue_count = 5'(count_after);
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (cmd_valid)
                    state_next = (cmd.action == ACT_ADD && cmd.job_ok) ? ST_SCAN : ST_DONE;
            ST_SCAN:
                if (scan_reg == tail_reg || hit)
                    state_next = ST_DONE;
            ST_DONE:
                if (cmd_ready)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Control registers, scan and dispatch
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            scan_reg      <= '0;
            dup_reg       <= 1'b0;
            waiting_reg   <= 1'b0;
            cur_blk_reg   <= '0;
            cur_wr_reg    <= 1'b0;
            wcnt_reg      <= WAIT_LIMIT_RST;
            res_valid_reg <= 1'b0;
            for (int i = 0; i < MAX_BLOCKS; i++)
            begin
                ds_reg[i] <= DS_OK;
                os_reg[i] <= OS_IDLE;
                lr_reg[i] <= LR_OK;
            end
        end
        else
        begin
            state_reg <= state_next;
            // Raise the result on completion, drop it once taken
            if (state_reg == ST_DONE && cmd_ready)
                res_valid_reg <= 1'b1;
            else if (res_ready)
                res_valid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    scan_reg <= head_reg;
                    dup_reg  <= 1'b0;
                end
                ST_SCAN:
                begin
                    if (scan_reg != tail_reg)
                    begin
                        if (hit)
                            dup_reg <= 1'b1;
                        scan_reg <= scan_inc;
                    end
                end
                ST_DONE:
                begin
                    if (cmd_ready)
                    begin
                        head_reg <= head_new;
                        tail_reg <= tail_new;
                        if (cmd.action == ACT_TICK && cmd.driver_idle)
                        begin
                            if (!waiting_reg)
                            begin
                                if (count != '0 && pop_blk_ok)
                                begin
                                    cur_blk_reg <= qb;
                                    cur_wr_reg  <= qw;
                                    lr_reg[qb]  <= LR_BUSY;
                                    os_reg[qb]  <= qw ? OS_WRITING : OS_READING;
                                    wcnt_reg    <= wait_limit;
                                    waiting_reg <= 1'b1;
                                end
                            end
                            else
                            begin
                                case (cmd.driver_result)
                                    DRV_OK:
                                    begin
                                        waiting_reg <= 1'b0;
                                        os_reg[cur_blk_reg] <= OS_IDLE;
                                        if (cur_wr_reg)
                                        begin
                                            ds_reg[cur_blk_reg] <= DS_WRITE_OK;
                                            lr_reg[cur_blk_reg] <= LR_OK;
                                        end
                                        else if (!cmd.id_ok)
                                        begin
                                            ds_reg[cur_blk_reg] <= DS_ID_ERR;
                                            lr_reg[cur_blk_reg] <= LR_FAILED;
                                        end
                                        else if (!cmd.checksum_ok)
                                        begin
                                            ds_reg[cur_blk_reg] <= DS_CSUM_ERR;
                                            lr_reg[cur_blk_reg] <= LR_FAILED;
                                        end
                                        else
                                        begin
                                            ds_reg[cur_blk_reg] <= DS_OK;
                                            lr_reg[cur_blk_reg] <= LR_OK;
                                        end
                                    end
                                    DRV_BUSY, DRV_ADDR, DRV_FAIL:
                                    begin
                                        if (cmd.driver_result == DRV_BUSY && wcnt_reg != '0)
                                            wcnt_reg <= wcnt_reg - 1'b1;
                                        else
                                        begin
                                            waiting_reg <= 1'b0;
                                            os_reg[cur_blk_reg] <= cur_wr_reg ?
                                                OS_WRITE_ERR : OS_READ_ERR;
                                            ds_reg[cur_blk_reg] <= cur_wr_reg ?
                                                DS_WRITE_FAIL : DS_READ_FAIL;
                                            lr_reg[cur_blk_reg] <= LR_FAILED;
                                        end
                                    end
                                    default:
                                        waiting_reg <= 1'b0;
                                endcase
                            end
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // Ring payload and result register
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_DONE && cmd_ready && tail_new != tail_reg)
            q_blk[tail_reg] <= {cmd.write, cb};
        if (state_reg == ST_DONE && cmd_ready)
            res_reg <= res_next;
    end
endmodule

// ===== rtl/nvm_job_queue_dispatcher.sv =====
// Top level of the storage job queue dispatcher.
`timescale 1ns / 1ps
// Usage:
//   s_axis carries one request item (add job, engine tick, query, no-op);
//   m_axis returns exactly one result item per request. cfg writes set
//   block_count (index 0) and wait_limit (index 1). The user must write them
//   only while the block is idle; the block does not enforce this. An item
//   passes a front register, then the back end. An add with a valid job
//   scans the waiting jobs one per cycle for a duplicate; other items skip it.
//   The duplicate scan over the job ring sets the rate; one item is worked
//   at a time in the back end while the front holds the next.
//   Reset empties the queue, clears all per-block status to ok/idle, sets
//   block_count to 8 and wait_limit to 1000. A stalled m_axis holds its
//   result; the back end then stops and the front fills and drops tready.
module nvm_job_queue_dispatcher (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // action[1:0]
    input  logic [1:0]  s_axis_tuser,
    // block[3:0], op[5:4], force_req[6], driver_idle[7],
    // driver_result[10:8], id_ok[11], checksum_ok[12], zero[15:13]
    input  logic [15:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // add_accepted[0], issue_valid[1], issue_block[4:2], issue_write[5],
    // finish_valid[6], engine_idle[7], query_data_status[10:8],
    // query_op_status[13:11], query_last_result[15:14], queue_count[20:16]
    output logic [23:0] m_axis_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data
);
    import njqd_pkg::*;

    logic [3:0]  block_count_reg;
    logic [15:0] wait_limit_reg;
    logic        cmd_valid, cmd_ready;
    cmd_t        cmd;
    res_t        res;

    assign cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_count_reg <= BLOCK_COUNT_RST;
            wait_limit_reg  <= WAIT_LIMIT_RST;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == REG_BLOCK_COUNT)
                block_count_reg <= cfg_data[3:0];
            else
                wait_limit_reg <= cfg_data;
        end
    end

    njqd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_user    (s_axis_tuser),
        .in_data    (s_axis_tdata[12:0]),
        .block_count(block_count_reg),
        .cmd_valid  (cmd_valid),
        .cmd_ready  (cmd_ready),
        .cmd        (cmd)
    );

    njqd_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (cmd_valid),
        .cmd_ready  (cmd_ready),
        .cmd        (cmd),
        .block_count(block_count_reg),
        .wait_limit (wait_limit_reg),
        .res_valid  (m_axis_tvalid),
        .res_ready  (m_axis_tready),
        .res        (res)
    );

    assign m_axis_tdata = {3'b000, res.queue_count, res.query_last_result,
                           res.query_op_status, res.query_data_status,
                           res.engine_idle, res.finish_valid, res.issue_write,
                           res.issue_block, res.issue_valid, res.add_accepted};

`ifndef ASSERT_OFF
    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[20:16] <= 5'(QUEUE_DEPTH)))
        else $error("queue count above depth");
    a_issue_finish: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !(m_axis_tdata[1] && m_axis_tdata[6]))
        else $error("issue and finish in one result");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
        else $error("stalled result changed");
`endif
endmodule
